// ----- hdl/ssrf_pkg.sv -----
// Shared types and constants for the stereo sample ring FIFO.
// No dependencies; imported by the FIFO top level.
`default_nettype none

package ssrf_pkg;

   localparam int ADDR_BITS   = 10;
   localparam int DEPTH       = 1 << ADDR_BITS;
   localparam int SAMPLE_BITS = 16;
   localparam int ENTRY_BITS  = 2 * SAMPLE_BITS;
   localparam int FILL_BITS   = 7;
   localparam int PROD_BITS   = ADDR_BITS + FILL_BITS;

   // Percent scale; occupancy * 100 / DEPTH becomes a multiply and a shift.
   localparam logic [PROD_BITS-1:0] PCT_SCALE = PROD_BITS'(100);

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_PULL = 1'b1;

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

endpackage

`default_nettype wire

// ----- hdl/ssrf_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ssrf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hdl/stereo_sample_ring_fifo_top.sv -----
// Stereo sample ring FIFO: top level with pointers, flags and result register.
// Depends on ssrf_pkg and ssrf_ram.
`default_nettype none

// Ring FIFO of 1024 stereo 16-bit sample pairs, one slot kept free (1023 usable).
// Each request word is a push (opcode 0) or a pull (opcode 1) and returns exactly
// one response word. A push, a rejected push and a pull from an empty buffer
// load the response register directly; a pull that returns data passes first
// through ST_READ for the registered read of the sample RAM. Requests are taken
// while a finished response waits to be consumed, as long as the response
// register is freed in the same cycle. overflow_flag is sticky until the next
// accepted push; fill_percent is recomputed on every pull and held across pushes.

module stereo_sample_ring_fifo_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic                                req_opcode,
   input  wire logic signed [ssrf_pkg::SAMPLE_BITS-1:0] req_right_in,
   input  wire logic signed [ssrf_pkg::SAMPLE_BITS-1:0] req_left_in,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic signed [ssrf_pkg::SAMPLE_BITS-1:0]  rsp_right_out,
   output logic signed [ssrf_pkg::SAMPLE_BITS-1:0]  rsp_left_out,
   output logic                                     rsp_was_empty,
   output logic                                     rsp_overflow_flag,
   output logic        [ssrf_pkg::FILL_BITS-1:0]    rsp_fill_percent
);

   import ssrf_pkg::*;

   state_type state_ff, state_in;
   logic [ADDR_BITS-1:0] wp_ff, wp_in;
   logic [ADDR_BITS-1:0] rp_ff, rp_in;
   logic                 ovf_ff, ovf_in;
   logic [FILL_BITS-1:0] fill_ff, fill_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] right_ff, right_in;
   logic signed [SAMPLE_BITS-1:0] left_ff, left_in;
   logic                 empty_ff, empty_in;

   logic                  accept;
   logic [ADDR_BITS-1:0]  wp_next;
   logic [ADDR_BITS-1:0]  rp_next;
   logic                  is_full;
   logic                  is_empty;
   logic [ADDR_BITS-1:0]  occ_after;
   logic [PROD_BITS-1:0]  fill_prod;

   logic                  ram_wr_en;
   logic                  ram_rd_en;
   logic [ENTRY_BITS-1:0] ram_wr_data;
   logic [ENTRY_BITS-1:0] ram_rd_data;

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   // Pointers wrap naturally at the power-of-two depth.
   assign wp_next   = wp_ff + ADDR_BITS'(1);
   assign rp_next   = rp_ff + ADDR_BITS'(1);
   assign is_full   = (wp_next == rp_ff);
   assign is_empty  = (wp_ff == rp_ff);
   assign occ_after = wp_ff - rp_next;
   assign fill_prod = PROD_BITS'(occ_after) * PCT_SCALE;

   assign ram_wr_data = {req_left_in, req_right_in};

   ssrf_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wp_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (rp_ff),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         rp_ff        <= '0;
         ovf_ff       <= 1'b0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         ovf_ff       <= ovf_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      right_ff <= right_in;
      left_ff  <= left_in;
      empty_ff <= empty_in;
   end

   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      rp_in        = rp_ff;
      ovf_in       = ovf_ff;
      fill_in      = fill_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      right_in     = right_ff;
      left_in      = left_ff;
      empty_in     = empty_ff;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               right_in = '0;
               left_in  = '0;
               empty_in = 1'b0;
               if (req_opcode == OP_PUSH) begin
                  rsp_valid_in = 1'b1;
                  if (is_full) begin
                     ovf_in = 1'b1;
                  end else begin
                     ram_wr_en = 1'b1;
                     wp_in     = wp_next;
                     ovf_in    = 1'b0;
                  end
               end else if (is_empty) begin
                  rsp_valid_in = 1'b1;
                  empty_in     = 1'b1;
                  fill_in      = '0;
               end else begin
                  // Fetch the oldest pair; ST_READ then loads it into the response register.
                  ram_rd_en = 1'b1;
                  rp_in     = rp_next;
                  fill_in   = fill_prod[ADDR_BITS +: FILL_BITS];
                  state_in  = ST_READ;
               end
            end
         end
         ST_READ: begin
            right_in     = $signed(ram_rd_data[SAMPLE_BITS-1:0]);
            left_in      = $signed(ram_rd_data[ENTRY_BITS-1:SAMPLE_BITS]);
            empty_in     = 1'b0;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_right_out     = right_ff;
   assign rsp_left_out      = left_ff;
   assign rsp_was_empty     = empty_ff;
   assign rsp_overflow_flag = ovf_ff;
   assign rsp_fill_percent  = fill_ff;

endmodule

`default_nettype wire
